// ===== design/pci_pkg.sv =====
// package for the palette colour indexer: shared types, widths and defaults
// no dependencies; imported by the interfaces and by every module of the block
`default_nettype none

package pci_pkg;

    // channel field widths
    localparam int CH_W        = 8;
    localparam int COLOR_W     = 3 * CH_W;
    localparam int IDX_OUT_W   = 8;
    localparam int COUNT_OUT_W = 9;

    // palette depth default, range 2 to 256
    localparam int TABLE_DEPTH_DEF = 256;

    // pixel queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COLOR_W-1:0] t_color;

    // head of the pixel queue as seen by the back end
    typedef struct packed {
        logic   valid;
        t_color color;
    } t_queue_head;

endpackage

`default_nettype wire

// ===== design/pci_if.sv =====
// valid/ready channel interfaces for pixels in and palette results out
// depends on pci_pkg for the field widths
`default_nettype none

interface pci_pix_if import pci_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface pci_res_if import pci_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [IDX_OUT_W-1:0]   color_index;
    logic                   added_new;
    logic                   table_full;
    logic [COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, output color_index, output added_new,
                    output table_full, output entry_count, input ready);
    modport sink   (input valid, input color_index, input added_new,
                    input table_full, input entry_count, output ready);
endinterface

`default_nettype wire

// ===== design/palette_color_indexer.sv =====
// Palette colour indexer, top level.
// Input channel i_pix carries one RGB pixel per transaction (red, green, blue).
// Output channel o_res returns one result per pixel: color_index, added_new,
// table_full and entry_count, in pixel order.
// The block keeps a palette of up to TABLE_DEPTH colours. A pixel whose colour
// is already stored gets that entry's index; otherwise the colour is appended
// and flagged as new. When the palette is full an unmatched colour is not
// stored: table_full is set and color_index is 0.
// Timing: the search reads one palette entry per cycle, so a pixel takes longer
// the later its matching entry lies, and an unmatched pixel scans every used
// entry; this memory scan sets the throughput.
// A two-deep pixel queue keeps accepting transactions while a search runs.
// Reset (synchronous, active low) empties the queue and the palette at once;
// no clearing pass is needed.
// If the receiver stalls, the finished result waits in the output register,
// the next search runs up to its result and holds there, and the queue fills
// before i_pix.ready drops.
// depends on pci_pkg, pci_if, pci_front and pci_back
`default_nettype none

module palette_color_indexer import pci_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pci_pix_if.sink     i_pix,
    pci_res_if.source   o_res
);

    t_queue_head head;
    logic        pop;

    // pixel intake and queue
    pci_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_head  (head),
        .i_pop   (pop)
    );

    // palette search and result stage
    pci_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== design/pci_front.sv =====
// front end: accepts pixel transactions, packs them into 24-bit colours
// and holds them in a short queue for the search engine; uses pci_pkg, pci_pix_if
`default_nettype none

module pci_front import pci_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pci_pix_if.sink      i_pix,
    output t_queue_head  o_head,
    input  wire logic    i_pop
);

    t_color              r_q_color [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QLVL_W-1:0]   r_level;
    logic                push;
    logic                pop;

    // queue flow control
    assign i_pix.ready = (r_level != QLVL_W'(QUEUE_DEPTH));
    assign push        = i_pix.valid && i_pix.ready;
    assign pop         = i_pop && (r_level != '0);

    assign o_head.valid = (r_level != '0);
    assign o_head.color = r_q_color[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_level <= r_level + QLVL_W'(1);
            end else if (pop && !push) begin
                r_level <= r_level - QLVL_W'(1);
            end
        end
    end

    // packed colour storage, red in the top byte
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_color[r_wr_ptr] <= {i_pix.red, i_pix.green, i_pix.blue};
        end
    end

endmodule

`default_nettype wire

// ===== design/pci_back.sv =====
// back end: palette memory, sequential search over the used entries,
// append on a miss and the registered result stage; uses pci_pkg, pci_res_if
`default_nettype none

module pci_back import pci_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_queue_head  i_head,
    output logic              o_pop,
    pci_res_if.source         o_res
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                 r_state;
    t_color                 r_mem [TABLE_DEPTH];
    t_color                 r_color;
    t_color                 r_rd_data;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_rd_idx;
    logic [IW-1:0]          r_chk_idx;
    logic                   r_chk_vld;
    logic                   r_res_valid;
    logic [IDX_OUT_W-1:0]   r_res_index;
    logic                   r_res_added;
    logic                   r_res_full;
    logic [COUNT_OUT_W-1:0] r_res_count;

    logic issue;
    logic hit;
    logic miss_end;
    logic done;
    logic advance;
    logic is_full;
    logic mem_we;
    logic mem_re;
    logic res_load;

    // search control
    assign issue    = (r_rd_idx < r_count);
    assign hit      = r_chk_vld && (r_rd_data == r_color);
    assign miss_end = !r_chk_vld && !issue;
    assign done     = hit || miss_end;
    assign advance  = !done || !r_res_valid || o_res.ready;
    assign is_full  = (r_count == CW'(TABLE_DEPTH));
    assign mem_re   = (r_state == S_SCAN) && advance && !done && issue;
    assign mem_we   = (r_state == S_SCAN) && advance && miss_end && !is_full;
    assign res_load = (r_state == S_SCAN) && advance && done;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;

    // result channel
    assign o_res.valid       = r_res_valid;
    assign o_res.color_index = r_res_index;
    assign o_res.added_new   = r_res_added;
    assign o_res.table_full  = r_res_full;
    assign o_res.entry_count = r_res_count;

    // palette memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
        end
        if (mem_we) begin
            r_mem[r_count[IW-1:0]] <= r_color;
        end
    end

    // state machine, fill count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_chk_vld   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            // result valid: set by a finished search, cleared when taken
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_color   <= i_head.color;
                        r_rd_idx  <= '0;
                        r_chk_vld <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (advance) begin
                        if (hit) begin
                            r_res_index <= IDX_OUT_W'(r_chk_idx);
                            r_res_added <= 1'b0;
                            r_res_full  <= 1'b0;
                            r_res_count <= COUNT_OUT_W'(r_count);
                            r_state     <= S_IDLE;
                        end else if (miss_end) begin
                            r_state     <= S_IDLE;
                            if (is_full) begin
                                r_res_index <= '0;
                                r_res_added <= 1'b0;
                                r_res_full  <= 1'b1;
                                r_res_count <= COUNT_OUT_W'(r_count);
                            end else begin
                                r_res_index <= IDX_OUT_W'(r_count[IW-1:0]);
                                r_res_added <= 1'b1;
                                r_res_full  <= 1'b0;
                                r_res_count <= COUNT_OUT_W'(r_count) + COUNT_OUT_W'(1);
                                r_count     <= r_count + CW'(1);
                            end
                        end else begin
                            r_chk_vld <= issue;
                            r_chk_idx <= r_rd_idx[IW-1:0];
                            if (issue) begin
                                r_rd_idx <= r_rd_idx + CW'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/pci_checker.sv =====
// port-level checker for the palette colour indexer, bound to the top level
// depends on pci_pkg; watches the result channel only
`default_nettype none

module pci_checker import pci_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_res_valid,
    input wire logic                   i_res_ready,
    input wire logic [IDX_OUT_W-1:0]   i_color_index,
    input wire logic                   i_added_new,
    input wire logic                   i_table_full,
    input wire logic [COUNT_OUT_W-1:0] i_entry_count
);

    // a result is never both new and rejected
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_added_new && i_table_full))
        else $error("added_new and table_full both set");

    // a rejected colour reports index 0 and a full palette
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_table_full) |->
            (i_color_index == '0) && (i_entry_count == COUNT_OUT_W'(TABLE_DEPTH)))
        else $error("full result with bad index or count");

    // a new entry is always the last one of the palette
    a_new_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_added_new) |->
            (COUNT_OUT_W'(i_color_index) + COUNT_OUT_W'(1) == i_entry_count))
        else $error("new entry index does not match entry count");

    // the entry count never exceeds the palette depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_entry_count <= COUNT_OUT_W'(TABLE_DEPTH)))
        else $error("entry count beyond palette depth");

    // a stalled result transaction holds its valid, index and entry count
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_color_index) && $stable(i_entry_count)))
        else $error("stalled result changed");

endmodule

bind palette_color_indexer pci_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_pci_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_color_index (o_res.color_index),
    .i_added_new   (o_res.added_new),
    .i_table_full  (o_res.table_full),
    .i_entry_count (o_res.entry_count)
);

`default_nettype wire

// ===== bench/tb_palette_color_indexer.sv =====
`timescale 1ns / 1ps
// testbench for palette_color_indexer: random and directed pixel transactions, palette predictor
// depends on pci_pkg, pci_if and the palette_color_indexer rtl

module tb_palette_color_indexer;
    import pci_pkg::*;

    localparam int  DEPTH          = 256;
    localparam int  TARGET_ITEMS   = 650;
    localparam int  MIN_FULL_ITEMS = 150;
    localparam int  REPORT_MAX     = 10;
    localparam int  DRAIN_CYCLES   = DEPTH + 40;
    localparam longint LIMIT_CYCLES = 1_000_000;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]   color_index;
        logic                   added_new;
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_palette_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pci_pix_if pix_ch ();
    pci_res_if res_ch ();

    palette_color_indexer #(.TABLE_DEPTH(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_color          pixel_backlog[$];
    t_palette_result pending_results[$];
    t_color          model_palette[$];

    int     stim_total   = 0;
    int     pixels_sent  = 0;
    int     errors       = 0;
    int     results_seen = 0;
    int     hits_seen    = 0;
    int     adds_seen    = 0;
    int     fulls_seen   = 0;
    longint cycles       = 0;
    bit     pix_took     = 1'b0;

    // lowest slot holding the colour, -1 when absent
    function automatic int find_colour(input t_color c, input t_color tab[$]);
        foreach (tab[k])
            if (tab[k] == c)
                return k;
        return -1;
    endfunction

    // palette lookup and append, updates the predicted palette
    function automatic t_palette_result index_pixel(input t_color c);
        int              slot;
        t_palette_result r;
        slot = find_colour(c, model_palette);
        r    = '0;
        if (slot >= 0) begin
            r.color_index = slot[IDX_OUT_W-1:0];
        end else if (model_palette.size() < DEPTH) begin
            r.color_index = IDX_OUT_W'(model_palette.size());
            r.added_new   = 1'b1;
            model_palette.insert(model_palette.size(), c);
        end else begin
            r.table_full = 1'b1;
        end
        r.entry_count = COUNT_OUT_W'(model_palette.size());
        return r;
    endfunction

    // pixel driver and result back-pressure, changes on the falling edge
    always @(negedge i_clk) begin : drive_pixels
        t_color next_pix;
        int     send_idle;
        int     recv_idle;
        if (pixels_sent < stim_total / 3) begin
            send_idle = 33;
            recv_idle = 64;
        end else if (pixels_sent < 2 * stim_total / 3) begin
            send_idle = 64;
            recv_idle = 33;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
            res_ch.ready <= 1'b0;
        end else begin
            // hold a transaction until it is taken
            if (!(pix_ch.valid && !pix_took)) begin
                if (pixel_backlog.size() > 0 && $urandom_range(99) >= send_idle) begin
                    next_pix     = pixel_backlog.pop_front();
                    pix_ch.red   <= next_pix[2*CH_W +: CH_W];
                    pix_ch.green <= next_pix[CH_W +: CH_W];
                    pix_ch.blue  <= next_pix[0 +: CH_W];
                    pix_ch.valid <= 1'b1;
                    pixels_sent++;
                end else begin
                    pix_ch.valid <= 1'b0;
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // prediction on accepted pixels, checking of accepted results
    always @(posedge i_clk) begin : observe
        t_palette_result got;
        t_palette_result want;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("palette_color_indexer verification failed");
            $finish;
        end else begin
            pix_took <= pix_ch.valid && pix_ch.ready;
            if (i_rst_n && pix_ch.valid && pix_ch.ready)
                pending_results.insert(pending_results.size(),
                    index_pixel({pix_ch.red, pix_ch.green, pix_ch.blue}));
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.color_index = res_ch.color_index;
                got.added_new   = res_ch.added_new;
                got.table_full  = res_ch.table_full;
                got.entry_count = res_ch.entry_count;
                results_seen++;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("stray result, cycle %0d: idx %0d new %0b full %0b cnt %0d",
                                 cycles, got.color_index, got.added_new,
                                 got.table_full, got.entry_count);
                end else begin
                    want = pending_results.pop_front();
                    if (want.table_full)
                        fulls_seen++;
                    else if (want.added_new)
                        adds_seen++;
                    else
                        hits_seen++;
                    if (got !== want) begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("result %0d exp/got: idx %0d/%0d new %0b/%0b %s",
                                     results_seen,
                                     want.color_index, got.color_index,
                                     want.added_new, got.added_new,
                                     $sformatf("full %0b/%0b cnt %0d/%0d",
                                               want.table_full, got.table_full,
                                               want.entry_count, got.entry_count));
                    end
                end
            end
        end
    end

    // stimulus build, reset and end of run
    initial begin : stimulus
        t_color gen_palette[$];
        t_color c;
        int     pick;
        int     post_items;

        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;
        res_ch.ready = 1'b0;

        // directed: channel extremes, repeats hitting low and high slots, single-bit neighbours
        pixel_backlog = {24'h000000, 24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                         24'h0000FF, 24'hFFFFFF, 24'h800000, 24'h008000, 24'h000080,
                         24'h010101, 24'h7F7F7F, 24'hFEFEFE, 24'hFF0000, 24'h0000FF,
                         24'h000001, 24'h000001, 24'h7F7F7E, 24'h000000, 24'h808080};
        foreach (pixel_backlog[k])
            if (find_colour(pixel_backlog[k], gen_palette) < 0)
                gen_palette.insert(gen_palette.size(), pixel_backlog[k]);

        // fill the palette: fresh colours, repeats and one-bit near misses
        while (gen_palette.size() < DEPTH) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                c = t_color'($urandom);
            end else if (pick < 85) begin
                c = gen_palette[$urandom_range(gen_palette.size() - 1)];
            end else begin
                c = gen_palette[$urandom_range(gen_palette.size() - 1)];
                c[$urandom_range(COLOR_W - 1)] ^= 1'b1;
            end
            if (find_colour(c, gen_palette) < 0)
                gen_palette.insert(gen_palette.size(), c);
            pixel_backlog.insert(pixel_backlog.size(), c);
        end

        // palette full: hits across the table and at its top, rejected colours
        post_items = TARGET_ITEMS - pixel_backlog.size();
        if (post_items < MIN_FULL_ITEMS)
            post_items = MIN_FULL_ITEMS;
        repeat (post_items) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                c = gen_palette[$urandom_range(DEPTH - 1)];
            end else if (pick < 45) begin
                c = gen_palette[$urandom_range(DEPTH - 1, DEPTH - 16)];
            end else if (pick < 80) begin
                c = t_color'($urandom);
            end else begin
                c = gen_palette[$urandom_range(DEPTH - 1)];
                c[$urandom_range(COLOR_W - 1)] ^= 1'b1;
            end
            pixel_backlog.insert(pixel_backlog.size(), c);
        end
        stim_total = pixel_backlog.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then allow a full-table search for stray results
        while (pixel_backlog.size() > 0 || pix_ch.valid || pending_results.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run covered %0d pixels over %0d cycles", stim_total, cycles);
        $display("%0d hits, %0d new entries, %0d full rejects; %0d results, %0d mismatches",
                 hits_seen, adds_seen, fulls_seen, results_seen, errors);
        if (errors == 0)
            $display("palette_color_indexer verification clean");
        else
            $display("palette_color_indexer verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pci_pkg.sv
design/pci_if.sv
design/pci_front.sv
design/pci_back.sv
design/palette_color_indexer.sv
design/pci_checker.sv
bench/tb_palette_color_indexer.sv
